// ===== rtl/mtg_pkg.sv =====
// Package for the MT19937 word generator: table geometry, recurrence and
// tempering constants, payload structs, controller states and command types.
// Depends on nothing; every other file of the block imports it.
package mtg_pkg;

	localparam int TABLE_WORDS         = 624;
	localparam int TWIST_OFFSET        = 397;
	localparam int WARMUP_DISCARDS_DEF = 10000;
	localparam int ADDR_W              = $clog2(TABLE_WORDS);
	localparam int POS_W               = $clog2(TABLE_WORDS + 1);

	localparam logic [31:0] INIT_MULT = 32'd1812433253;
	localparam logic [31:0] MATRIX_A  = 32'h9908_B0DF;
	localparam logic [31:0] TEMPER_B  = 32'h9D2C_5680;
	localparam logic [31:0] TEMPER_C  = 32'hEFC6_0000;

	localparam logic REQ_DRAW = 1'b0;
	localparam logic REQ_SEED = 1'b1;

	localparam logic STATUS_OK         = 1'b0;
	localparam logic STATUS_NOT_SEEDED = 1'b1;

	typedef struct packed {
		logic        req_type;
		logic [31:0] seed_value;
	} mtg_req_t;

	typedef struct packed {
		logic [31:0] random_word;
		logic        status;
	} mtg_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEED_MUL,
		ST_SEED_WR,
		ST_WARM,
		ST_TW_INIT,
		ST_TW_RD,
		ST_TW_WR,
		ST_DRAW_RD,
		ST_DRAW_OUT,
		ST_ACK,
		ST_REFUSE
	} mtg_state_t;

	typedef enum logic [1:0] {
		OUT_WORD,
		OUT_ACK,
		OUT_REFUSE
	} mtg_out_sel_t;

	typedef struct packed {
		logic         idle;
		logic         seed_load;
		logic         seed_mul;
		logic         seed_wr;
		logic         warm_step;
		logic         tw_init;
		logic         tw_rd;
		logic         tw_wr;
		logic         draw_rd;
		logic         draw_hold;
		logic         out_load;
		mtg_out_sel_t out_sel;
		logic         set_seeded;
	} mtg_cmd_t;

	typedef struct packed {
		logic seeded;
		logic pos_end;
		logic k_last;
		logic disc_done;
		logic out_free;
	} mtg_sts_t;

endpackage

// ===== rtl/mtg_ctrl.sv =====
// Controller state machine of the MT19937 generator: sequences seeding,
// warm-up, table twists and draws. Depends on mtg_pkg.
module mtg_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic              req_type,
	input  mtg_pkg::mtg_sts_t sts,
	output mtg_pkg::mtg_cmd_t cmd
);
	import mtg_pkg::*;

	mtg_state_t state_q, state_d;
	logic       ret_draw_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			ret_draw_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && req_valid) begin
				ret_draw_q <= (req_type == REQ_DRAW);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					if (req_type == REQ_SEED) begin
						state_d = ST_SEED_MUL;
					end else if (!sts.seeded) begin
						state_d = ST_REFUSE;
					end else if (sts.pos_end) begin
						state_d = ST_TW_INIT;
					end else begin
						state_d = ST_DRAW_RD;
					end
				end
			end
			ST_SEED_MUL: state_d = ST_SEED_WR;
			ST_SEED_WR: begin
				state_d = sts.k_last ? ST_WARM : ST_SEED_MUL;
			end
			ST_WARM: begin
				if (sts.disc_done) begin
					state_d = ST_ACK;
				end else if (sts.pos_end) begin
					state_d = ST_TW_INIT;
				end
			end
			ST_TW_INIT: state_d = ST_TW_RD;
			ST_TW_RD:   state_d = ST_TW_WR;
			ST_TW_WR: begin
				if (sts.k_last) begin
					state_d = ret_draw_q ? ST_DRAW_RD : ST_WARM;
				end else begin
					state_d = ST_TW_RD;
				end
			end
			ST_DRAW_RD: state_d = ST_DRAW_OUT;
			ST_DRAW_OUT, ST_ACK, ST_REFUSE: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.idle      = 1'b1;
				cmd.seed_load = req_valid && (req_type == REQ_SEED);
			end
			ST_SEED_MUL: cmd.seed_mul = 1'b1;
			ST_SEED_WR:  cmd.seed_wr  = 1'b1;
			ST_WARM:     cmd.warm_step = !sts.disc_done && !sts.pos_end;
			ST_TW_INIT:  cmd.tw_init  = 1'b1;
			ST_TW_RD:    cmd.tw_rd    = 1'b1;
			ST_TW_WR:    cmd.tw_wr    = 1'b1;
			ST_DRAW_RD:  cmd.draw_rd  = 1'b1;
			ST_DRAW_OUT: begin
				// The word read for this draw must survive a stalled result register.
				cmd.draw_hold = 1'b1;
				cmd.out_load  = sts.out_free;
				cmd.out_sel   = OUT_WORD;
			end
			ST_ACK: begin
				cmd.out_load   = sts.out_free;
				cmd.out_sel    = OUT_ACK;
				cmd.set_seeded = sts.out_free;
			end
			ST_REFUSE: begin
				cmd.out_load = sts.out_free;
				cmd.out_sel  = OUT_REFUSE;
			end
			default: cmd = '0;
		endcase
	end

endmodule

// ===== rtl/mtg_datapath.sv =====
// Datapath of the MT19937 generator: state table memory, seeding multiplier,
// twist and tempering logic, counters and the result register. Depends on mtg_pkg.
module mtg_datapath #(
	parameter int WARMUP_DISCARDS = mtg_pkg::WARMUP_DISCARDS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  mtg_pkg::mtg_req_t req_data,
	input  mtg_pkg::mtg_cmd_t cmd,
	output mtg_pkg::mtg_sts_t sts,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output mtg_pkg::mtg_rsp_t rsp_data
);
	import mtg_pkg::*;

	localparam int DiscW = (WARMUP_DISCARDS < 1) ? 1 : $clog2(WARMUP_DISCARDS + 1);

	logic [31:0] mem [TABLE_WORDS];
	logic [31:0] rd_a_q, rd_b_q;

	logic [ADDR_W-1:0] k_q;
	logic [POS_W-1:0]  pos_q;
	logic [DiscW-1:0]  disc_q;
	logic              seeded_q;
	logic [31:0]       p_q, prod_q, cur_q;
	logic              out_valid_q;
	mtg_rsp_t          out_q;

	logic [ADDR_W-1:0] nxt_addr, far_addr, rd_a_addr;
	logic [ADDR_W:0]   far_sum;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [31:0]       wr_data, seed_word, twist_word, v, sh;

	function automatic logic [31:0] temper(input logic [31:0] x);
		logic [31:0] w;
		w = x ^ (x >> 11);
		w = w ^ ((w << 7) & TEMPER_B);
		w = w ^ ((w << 15) & TEMPER_C);
		w = w ^ (w >> 18);
		return w;
	endfunction

	assign nxt_addr = (k_q == ADDR_W'(TABLE_WORDS - 1)) ? '0 : k_q + ADDR_W'(1);
	assign far_sum  = {1'b0, k_q} + (ADDR_W + 1)'(TWIST_OFFSET);
	assign far_addr = (far_sum >= (ADDR_W + 1)'(TABLE_WORDS))
	                ? ADDR_W'(far_sum - (ADDR_W + 1)'(TABLE_WORDS))
	                : far_sum[ADDR_W-1:0];

	// Twist: upper bit of the current word joined to the lower bits of the next.
	assign v          = {cur_q[31], rd_a_q[30:0]};
	assign sh         = (v >> 1) ^ (v[0] ? MATRIX_A : 32'd0);
	assign twist_word = rd_b_q ^ sh;
	assign seed_word  = prod_q + 32'(k_q);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = k_q;
		wr_data = seed_word;
		if (cmd.seed_load) begin
			wr_en   = 1'b1;
			wr_addr = '0;
			wr_data = req_data.seed_value;
		end else if (cmd.seed_wr) begin
			wr_en = 1'b1;
		end else if (cmd.tw_wr) begin
			wr_en   = 1'b1;
			wr_data = twist_word;
		end
	end

	always_comb begin
		rd_a_addr = nxt_addr;
		if (cmd.tw_init) begin
			rd_a_addr = '0;
		end else if (cmd.draw_rd) begin
			rd_a_addr = pos_q[ADDR_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (!cmd.draw_hold) begin
			rd_a_q <= mem[rd_a_addr];
		end
		rd_b_q <= mem[far_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.seed_load) begin
			p_q <= req_data.seed_value;
		end else if (cmd.seed_wr) begin
			p_q <= seed_word;
		end
		if (cmd.seed_mul) begin
			prod_q <= INIT_MULT * (p_q ^ (p_q >> 30));
		end
		// The first twist step takes word zero from the read issued at start.
		if (cmd.tw_rd && k_q == '0) begin
			cur_q <= rd_a_q;
		end else if (cmd.tw_wr) begin
			cur_q <= rd_a_q;
		end
		if (cmd.out_load) begin
			case (cmd.out_sel)
				OUT_WORD: begin
					out_q.random_word <= temper(rd_a_q);
					out_q.status      <= STATUS_OK;
				end
				OUT_ACK: begin
					out_q.random_word <= '0;
					out_q.status      <= STATUS_OK;
				end
				OUT_REFUSE: begin
					out_q.random_word <= '0;
					out_q.status      <= STATUS_NOT_SEEDED;
				end
				default: begin
					out_q.random_word <= '0;
					out_q.status      <= STATUS_OK;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q         <= '0;
			pos_q       <= POS_W'(TABLE_WORDS);
			disc_q      <= '0;
			seeded_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.seed_load) begin
				k_q    <= ADDR_W'(1);
				pos_q  <= POS_W'(TABLE_WORDS);
				disc_q <= '0;
			end else if (cmd.seed_wr || cmd.tw_wr) begin
				k_q <= sts.k_last ? '0 : k_q + ADDR_W'(1);
			end else if (cmd.tw_init) begin
				k_q <= '0;
			end
			if (cmd.tw_wr && sts.k_last) begin
				pos_q <= '0;
			end else if (cmd.draw_rd || cmd.warm_step) begin
				pos_q <= pos_q + POS_W'(1);
			end
			if (cmd.warm_step) begin
				disc_q <= disc_q + DiscW'(1);
			end
			if (cmd.set_seeded) begin
				seeded_q <= 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.seeded    = seeded_q;
	assign sts.pos_end   = (pos_q >= POS_W'(TABLE_WORDS));
	assign sts.k_last    = (k_q == ADDR_W'(TABLE_WORDS - 1));
	assign sts.disc_done = (disc_q == DiscW'(WARMUP_DISCARDS));
	assign sts.out_free  = !out_valid_q || !rsp_stall;

	assign rsp_valid = out_valid_q;
	assign rsp_data  = out_q;

endmodule

// ===== rtl/mersenne_twister_generator.sv =====
// Top level of the MT19937 32-bit word generator: joins controller and datapath.
// Depends on mtg_pkg, mtg_ctrl and mtg_datapath.
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_valid / req_stall  mtg_req_t (req_type, seed_value)
//   rsp      out        rsp_valid / rsp_stall  mtg_rsp_t (random_word, status)
//
// A draw reads a table word and registers its tempered value; a draw that finds all
// 624 words used first twists the table with a read and a write state per word. A seed
// fills the table with a multiply and a write state per word, then makes the warm-up
// discards, with one twist per 624 discards. Reset sets the read position to the end
// of the table and clears the seeded flag; the table itself is not cleared. A stalled
// result waits in the output register while the next request can already be accepted.
module mersenne_twister_generator #(
	parameter int WARMUP_DISCARDS = mtg_pkg::WARMUP_DISCARDS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  mtg_pkg::mtg_req_t req_data,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output mtg_pkg::mtg_rsp_t rsp_data
);
	import mtg_pkg::*;

	mtg_cmd_t cmd;
	mtg_sts_t sts;

	// Requests are taken only while the controller is idle.
	assign req_stall = !cmd.idle;

	mtg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_type  (req_data.req_type),
		.sts       (sts),
		.cmd       (cmd)
	);

	mtg_datapath #(
		.WARMUP_DISCARDS (WARMUP_DISCARDS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_data  (req_data),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data)
	);

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the MT19937 word generator: a directed table, then seeded
// runs of random draws; each response is checked against a typed table entry or a model.
// Depends on mtg_pkg and mersenne_twister_generator.
module testbench;
	import mtg_pkg::*;

	localparam int          RAND_ITEMS   = 1250;
	localparam int          CALM_ITEMS   = 150;
	localparam int          DRAIN_CYCLES = 64;
	localparam logic [31:0] UPPER_MASK   = 32'h8000_0000;
	localparam logic [31:0] LOWER_MASK   = 32'h7FFF_FFFF;

	typedef struct packed {
		mtg_req_t req;
		logic     typed;
		mtg_rsp_t rsp;
	} dir_row_t;

	logic     clk;
	logic     arst_n    = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_stall;
	mtg_req_t req_data  = '0;
	logic     rsp_valid;
	logic     rsp_stall = 1'b0;
	mtg_rsp_t rsp_data;

	// Generator model
	logic [31:0] mt_words [TABLE_WORDS];
	int unsigned mt_pos;
	bit          mt_seeded;

	mtg_rsp_t awaited_rsp_q [$];
	int       errors   = 0;
	bit       quiet    = 1'b0;
	int       idle_pct = 20;
	int       stall_cnt = 0;

	dir_row_t dir_rows [20];

	mersenne_twister_generator #(
		.WARMUP_DISCARDS(WARMUP_DISCARDS_DEF)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data (req_data),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_data (rsp_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function void twist_words();
		logic [31:0] v;
		logic [31:0] sh;
		for (int k = 0; k < TABLE_WORDS; k++) begin
			v  = (mt_words[k] & UPPER_MASK) | (mt_words[(k + 1) % TABLE_WORDS] & LOWER_MASK);
			sh = v >> 1;
			if (v[0]) begin
				sh ^= MATRIX_A;
			end
			mt_words[k] = mt_words[(k + TWIST_OFFSET) % TABLE_WORDS] ^ sh;
		end
		mt_pos = 0;
	endfunction

	function logic [31:0] next_tempered();
		logic [31:0] w;
		if (mt_pos >= TABLE_WORDS) begin
			twist_words();
		end
		w = mt_words[mt_pos];
		mt_pos++;
		w ^= w >> 11;
		w ^= (w << 7) & TEMPER_B;
		w ^= (w << 15) & TEMPER_C;
		w ^= w >> 18;
		return w;
	endfunction

	function void seed_words(logic [31:0] seed);
		logic [31:0] p;
		mt_words[0] = seed;
		for (int k = 1; k < TABLE_WORDS; k++) begin
			p           = mt_words[k - 1];
			mt_words[k] = INIT_MULT * (p ^ (p >> 30)) + 32'(k);
		end
		mt_pos = TABLE_WORDS;
		for (int n = 0; n < WARMUP_DISCARDS_DEF; n++) begin
			void'(next_tempered());
		end
		mt_seeded = 1'b1;
	endfunction

	function mtg_rsp_t mt_response(mtg_req_t req);
		mtg_rsp_t rsp;
		rsp = '{random_word: 32'h0, status: STATUS_OK};
		if (req.req_type == REQ_SEED) begin
			seed_words(req.seed_value);
		end else if (!mt_seeded) begin
			rsp.status = STATUS_NOT_SEEDED;
		end else begin
			rsp.random_word = next_tempered();
		end
		return rsp;
	endfunction

	// The expectation is formed at the edge on which the transaction is accepted.
	task automatic send_req(input mtg_req_t req, input logic typed, input mtg_rsp_t typed_rsp);
		mtg_rsp_t predicted;
		int       gap;
		if (!quiet && $urandom_range(0, 99) < idle_pct) begin
			gap = $urandom_range(1, 13);
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_data  <= req;
		do @(posedge clk); while (req_stall);
		predicted = mt_response(req);
		awaited_rsp_q.push_back(typed ? typed_rsp : predicted);
	endtask

	// Receiver back-pressure in bursts.
	always @(posedge clk) begin
		if (!quiet && stall_cnt == 0 && $urandom_range(0, 5) == 0) begin
			stall_cnt = $urandom_range(1, 13);
		end
		if (stall_cnt > 0) begin
			rsp_stall <= 1'b1;
			stall_cnt--;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		mtg_rsp_t exp_rsp;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (awaited_rsp_q.size() == 0) begin
				$display("%0t: unexpected response: random_word %h status %b", $time,
					rsp_data.random_word, rsp_data.status);
				errors++;
			end else begin
				exp_rsp = awaited_rsp_q.pop_front();
				if (rsp_data.random_word !== exp_rsp.random_word) begin
					$display("%0t: random_word mismatch: expected %h, actual %h", $time,
						exp_rsp.random_word, rsp_data.random_word);
					errors++;
				end
				if (rsp_data.status !== exp_rsp.status) begin
					$display("%0t: status mismatch: expected %b, actual %b", $time,
						exp_rsp.status, rsp_data.status);
					errors++;
				end
			end
		end
	end

	initial begin
		#20_000_000;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		mtg_req_t req;
		int       rand_sent;
		int       seg_len;
		bit       first_seg;

		for (int k = 0; k < TABLE_WORDS; k++) begin
			mt_words[k] = 32'h0;
		end
		mt_pos    = TABLE_WORDS;
		mt_seeded = 1'b0;

		dir_rows = '{
			'{'{REQ_DRAW, 32'h0000_0000}, 1'b1, '{32'h0, STATUS_NOT_SEEDED}},
			'{'{REQ_DRAW, 32'hFFFF_FFFF}, 1'b1, '{32'h0, STATUS_NOT_SEEDED}},
			'{'{REQ_SEED, 32'h0000_0000}, 1'b1, '{32'h0, STATUS_OK}},
			'{'{REQ_DRAW, 32'h0000_0000}, 1'b0, '{32'h0, STATUS_OK}},
			'{'{REQ_DRAW, 32'hFFFF_FFFF}, 1'b0, '{32'h0, STATUS_OK}},
			'{'{REQ_SEED, 32'hFFFF_FFFF}, 1'b1, '{32'h0, STATUS_OK}},
			'{'{REQ_DRAW, 32'h0000_0000}, 1'b0, '{32'h0, STATUS_OK}},
			'{'{REQ_DRAW, 32'h0000_0000}, 1'b0, '{32'h0, STATUS_OK}},
			'{'{REQ_SEED, 32'd5489},      1'b1, '{32'h0, STATUS_OK}},
			'{'{REQ_DRAW, 32'h8000_0000}, 1'b0, '{32'h0, STATUS_OK}},
			'{'{REQ_DRAW, 32'h0000_0001}, 1'b0, '{32'h0, STATUS_OK}},
			'{'{REQ_DRAW, 32'h5555_5555}, 1'b0, '{32'h0, STATUS_OK}},
			'{'{REQ_DRAW, 32'hAAAA_AAAA}, 1'b0, '{32'h0, STATUS_OK}},
			'{'{REQ_SEED, 32'h8000_0000}, 1'b1, '{32'h0, STATUS_OK}},
			'{'{REQ_DRAW, 32'h0000_0000}, 1'b0, '{32'h0, STATUS_OK}},
			'{'{REQ_SEED, 32'h0000_0001}, 1'b1, '{32'h0, STATUS_OK}},
			'{'{REQ_SEED, 32'h7FFF_FFFF}, 1'b1, '{32'h0, STATUS_OK}},
			'{'{REQ_DRAW, 32'h0000_0000}, 1'b0, '{32'h0, STATUS_OK}},
			'{'{REQ_DRAW, 32'hFFFF_FFFF}, 1'b0, '{32'h0, STATUS_OK}},
			'{'{REQ_DRAW, 32'h0000_0000}, 1'b0, '{32'h0, STATUS_OK}}
		};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);
		end

		// Each random run starts with a reseed once every outstanding response is back.
		// The first run is long enough to cross a table regeneration.
		rand_sent = 0;
		first_seg = 1'b1;
		while (rand_sent < RAND_ITEMS) begin
			req_valid <= 1'b0;
			while (awaited_rsp_q.size() != 0) @(posedge clk);
			idle_pct = $urandom_range(0, 2) * 15;
			quiet    = (rand_sent >= RAND_ITEMS - CALM_ITEMS);
			req.req_type   = REQ_SEED;
			req.seed_value = $urandom;
			send_req(req, 1'b0, '0);
			rand_sent++;
			seg_len   = first_seg ? $urandom_range(640, 800) : $urandom_range(100, 800);
			first_seg = 1'b0;
			for (int n = 0; n < seg_len && rand_sent < RAND_ITEMS; n++) begin
				quiet          = (rand_sent >= RAND_ITEMS - CALM_ITEMS);
				req.req_type   = REQ_DRAW;
				req.seed_value = $urandom;
				send_req(req, 1'b0, '0);
				rand_sent++;
			end
		end
		req_valid <= 1'b0;

		while (awaited_rsp_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
